// ===== design/bba_pkg.sv =====
`default_nettype none
package bba_pkg;

  typedef enum logic [2:0] {
    CMD_ALLOC  = 3'd0,
    CMD_FREE   = 3'd1,
    CMD_VERIFY = 3'd2,
    CMD_SIZE   = 3'd3,
    CMD_LOAD   = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ILLEGAL  = 3'd1;
  localparam logic [2:0] ST_CROSS    = 3'd2;
  localparam logic [2:0] ST_NOTALLOC = 3'd3;
  localparam logic [2:0] ST_NOSPACE  = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] block_index;
    logic [31:0] byte_offset;
    logic [13:0] used_blocks;
    logic [31:0] estimated_size;
    logic [31:0] word_out;
    logic        dirty;
  } result_t;

  // Mask of n low ones, n up to 32.
  function automatic logic [31:0] run_mask(input logic [5:0] n);
    logic [32:0] t;
    t = (33'd1 << n) - 33'd1;
    return t[31:0];
  endfunction

  // Lowest bit position holding n free blocks in a row; found flag in bit 5.
  function automatic logic [5:0] first_fit(input logic [31:0] freew, input logic [5:0] n);
    logic [31:0] m;
    logic [5:0]  r;
    m = run_mask(n);
    r = 6'd0;
    for (int b = 31; b >= 0; b--) begin
      if ((6'(b) + n <= 6'd32) && (((freew >> b) & m) == m)) begin
        r = {1'b1, 5'(b)};
      end
    end
    return r;
  endfunction

  // Index of highest set bit.
  function automatic logic [4:0] top_bit(input logic [31:0] w);
    logic [4:0] r;
    r = 5'd0;
    for (int b = 0; b < 32; b++) begin
      if (w[b]) begin
        r = 5'(b);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/bba_map_ram.sv =====
`default_nettype none
module bba_map_ram #(
  parameter int AW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);
  logic [31:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/block_bitmap_allocator_unit.sv =====
`default_nettype none
// Channel  | Direction | Ports
// in       | input     | in_valid, in_ready, in_cmd ... in_word_data
// out      | output    | out_valid, out_ready, out_status ... out_dirty
// cfg      | input     | cfg_we, cfg_data (block_size)
//
// After reset a clearing pass zeroes every bitmap word, one per cycle.
// Allocate and size query: decode, a sweep through the single read port, multiply
// (skipped when allocation finds no room) and output. Free, verify and read pass
// through decode, read, check and write back, and output; load and rejected words
// go from decode to output. in_ready is high only in the idle cycle between words;
// a result still waiting in the output register holds the next word at its end.
module block_bitmap_allocator_unit #(
  parameter int MAP_WORDS = 256,
  parameter int MAX_RUN   = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [12:0] in_start_block,
  input  wire logic [2:0]  in_num_blocks,
  input  wire logic [7:0]  in_word_index,
  input  wire logic [31:0] in_word_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [2:0]  out_status,
  output logic      [12:0] out_block_index,
  output logic      [31:0] out_byte_offset,
  output logic      [13:0] out_used_blocks,
  output logic      [31:0] out_estimated_size,
  output logic      [31:0] out_word_out,
  output logic             out_dirty,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_data
);
  import bba_pkg::*;

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [31:0] MAP_BYTES = 32'(MAP_WORDS * 4);
  localparam logic [AW:0] LAST = (AW + 1)'(MAP_WORDS - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [16:0] bsize_r;
  logic        dirty_r, dirty_nxt;
  logic [2:0]  cmd_r;
  logic [12:0] start_r;
  logic [5:0]  n_r;
  logic [7:0]  widx_r;
  logic [31:0] wdata_r;
  logic [AW:0] addr_r, addr_nxt;   // sweep counter
  logic [AW:0] paddr_r;            // address of data now on rdata
  logic        pvalid_r;
  logic [2:0]  st_r, st_nxt;
  logic [13:0] idx_r, idx_nxt;     // block index or used extent
  logic [31:0] wout_r, wout_nxt;
  result_t     res_r;
  logic        res_v_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wd, rdata;

  bba_map_ram #(.AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wd), .raddr(raddr), .rdata(rdata)
  );

  logic        run_ok, widx_ok, start_ok;
  logic [5:0]  bitpos;
  logic [31:0] rmask;
  logic [5:0]  fit;
  logic [31:0] prod;

  assign run_ok   = (n_r >= 6'd1) && (n_r <= 6'(MAX_RUN));
  assign widx_ok  = 32'(widx_r) < 32'(MAP_WORDS);
  assign start_ok = 32'(start_r) < 32'(MAP_WORDS * 32);
  assign bitpos   = {1'b0, start_r[4:0]};
  assign rmask    = run_mask(n_r) << bitpos;
  assign fit      = first_fit(~rdata, n_r);
  assign prod     = 32'(idx_r) * 32'(bsize_r);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    dirty_nxt = dirty_r;
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    wout_nxt  = wout_r;
    we        = 1'b0;
    waddr     = addr_r[AW-1:0];
    wd        = 32'd0;
    raddr     = addr_r[AW-1:0];
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          st_nxt = ST_ILLEGAL;
          idx_nxt = 14'd0;
          wout_nxt = 32'd0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        // Decide and set up the first read address.
        state_nxt = S_OUT;
        case (cmd_r)
          CMD_ALLOC: begin
            if (run_ok) begin
              st_nxt = ST_NOSPACE;
              addr_nxt = '0;
              state_nxt = S_SCAN;
            end
          end
          CMD_SIZE: begin
            st_nxt = ST_OK;
            addr_nxt = LAST;
            state_nxt = S_SCAN;
          end
          CMD_FREE, CMD_VERIFY: begin
            if (start_ok && run_ok) begin
              if (bitpos + n_r > 6'd32) begin
                st_nxt = (cmd_r == CMD_FREE) ? ST_CROSS : ST_ILLEGAL;
              end else begin
                addr_nxt = (AW + 1)'(start_r[12:5]);
                state_nxt = S_CHK;
              end
            end
          end
          CMD_LOAD: begin
            if (widx_ok) begin
              we = 1'b1;
              waddr = AW'(widx_r);
              wd = wdata_r;
              st_nxt = ST_OK;
            end
          end
          CMD_READ: begin
            if (widx_ok) begin
              addr_nxt = (AW + 1)'(widx_r);
              state_nxt = S_CHK;
            end
          end
          default: ;
        endcase
      end
      S_CHK: begin
        // The read is issued in the first cycle here; data is valid when pvalid_r.
        if (pvalid_r) begin
          state_nxt = S_OUT;
          if (cmd_r == CMD_READ) begin
            wout_nxt = rdata;
            dirty_nxt = 1'b0;
            st_nxt = ST_OK;
          end else if ((rdata & rmask) != rmask) begin
            st_nxt = ST_NOTALLOC;
          end else begin
            st_nxt = ST_OK;
            if (cmd_r == CMD_FREE) begin
              we = 1'b1;
              waddr = paddr_r[AW-1:0];
              wd = rdata ^ rmask;
              dirty_nxt = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        if (cmd_r == CMD_ALLOC) begin
          if (addr_r != LAST + 1'b1) begin
            addr_nxt = addr_r + 1'b1;
          end
          if (pvalid_r && fit[5]) begin
            we = 1'b1;
            waddr = paddr_r[AW-1:0];
            wd = rdata | (run_mask(n_r) << fit[4:0]);
            dirty_nxt = 1'b1;
            st_nxt = ST_OK;
            idx_nxt = 14'({paddr_r, 5'd0}) + 14'(fit[4:0]);
            state_nxt = S_MUL;
          end else if (pvalid_r && paddr_r == LAST) begin
            state_nxt = S_OUT;
          end
        end else begin
          if (addr_r != '0) begin
            addr_nxt = addr_r - 1'b1;
          end
          if (pvalid_r && rdata != 32'd0) begin
            idx_nxt = 14'({paddr_r, 5'd0}) + 14'(top_bit(rdata)) + 14'd1;
            state_nxt = S_MUL;
          end else if (pvalid_r && paddr_r == '0) begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!res_v_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      addr_r   <= '0;
      bsize_r  <= 17'd256;
      dirty_r  <= 1'b0;
      res_v_r  <= 1'b0;
      pvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      dirty_r  <= dirty_nxt;
      if (cfg_we) begin
        bsize_r <= cfg_data;
      end
      // A read issued from addr_r in a check or sweep cycle returns data next cycle.
      pvalid_r <= (state_r == S_CHK && state_nxt == S_CHK) ||
                  (state_r == S_SCAN && state_nxt == S_SCAN);
      if (res_v_r && out_ready) begin
        res_v_r <= 1'b0;
      end
      if (state_r == S_OUT && (!res_v_r || out_ready)) begin
        res_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    paddr_r <= addr_r;
    st_r    <= st_nxt;
    idx_r   <= idx_nxt;
    wout_r  <= wout_nxt;
    if (state_r == S_IDLE && in_valid) begin
      cmd_r   <= in_cmd;
      start_r <= in_start_block;
      n_r     <= {3'd0, in_num_blocks};
      widx_r  <= in_word_index;
      wdata_r <= in_word_data;
    end
    if (state_r == S_OUT && (!res_v_r || out_ready)) begin
      res_r.status         <= st_r;
      res_r.block_index    <= 13'd0;
      res_r.byte_offset    <= 32'd0;
      res_r.used_blocks    <= 14'd0;
      res_r.estimated_size <= 32'd0;
      res_r.word_out       <= wout_r;
      res_r.dirty          <= dirty_r;
      if (cmd_r == CMD_ALLOC && st_r == ST_OK) begin
        res_r.block_index <= idx_r[12:0];
        res_r.byte_offset <= MAP_BYTES + prod;
      end
      if (cmd_r == CMD_SIZE) begin
        res_r.used_blocks    <= idx_r;
        res_r.estimated_size <= MAP_BYTES + prod;
      end
    end
  end

  assign out_valid          = res_v_r;
  assign out_status         = res_r.status;
  assign out_block_index    = res_r.block_index;
  assign out_byte_offset    = res_r.byte_offset;
  assign out_used_blocks    = res_r.used_blocks;
  assign out_estimated_size = res_r.estimated_size;
  assign out_word_out       = res_r.word_out;
  assign out_dirty          = res_r.dirty;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ready) else $error("accept during clear");
  a_write_one_place: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CLEAR || state_r == S_RD || state_r == S_CHK ||
            state_r == S_SCAN)) else $error("stray write");
  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_OUT) else $error("result out of order");
endmodule
`default_nettype wire

// ===== dv/block_bitmap_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module block_bitmap_allocator_unit_tb;
  import bba_pkg::*;

  // Command codes beyond the defined set; the block must reject them.
  localparam logic [2:0] CMD_UNUSED_A = 3'd6;
  localparam logic [2:0] CMD_UNUSED_B = 3'd7;
  localparam int NUM_WORDS = 256;
  localparam int MAP_BYTES = NUM_WORDS * 4;
  localparam int HOT_WORDS = 8;
  localparam int LONG_HOLD = 600;
  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_cmd;
  logic [12:0] in_start_block;
  logic [2:0]  in_num_blocks;
  logic [7:0]  in_word_index;
  logic [31:0] in_word_data;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [12:0] out_block_index;
  logic [31:0] out_byte_offset;
  logic [13:0] out_used_blocks;
  logic [31:0] out_estimated_size;
  logic [31:0] out_word_out;
  logic        out_dirty;
  logic        cfg_we;
  logic [16:0] cfg_data;

  // Our own copy of the allocator state, kept in step with accepted words.
  logic [31:0] usage_words [NUM_WORDS];
  logic        map_dirty_q;
  logic [16:0] block_bytes;

  result_t pending_results [$];
  int      mismatch_count;
  int      quiet_cycles;
  bit      no_idle;
  bit      long_hold_req;
  int      out_stall_left;

  block_bitmap_allocator_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_start_block    (in_start_block),
    .in_num_blocks     (in_num_blocks),
    .in_word_index     (in_word_index),
    .in_word_data      (in_word_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_block_index   (out_block_index),
    .out_byte_offset   (out_byte_offset),
    .out_used_blocks   (out_used_blocks),
    .out_estimated_size(out_estimated_size),
    .out_word_out      (out_word_out),
    .out_dirty         (out_dirty),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Computes the result of one command word and applies its effect to the
  // local bitmap, exactly as the block is meant to.
  function automatic result_t allocator_result(input logic [2:0] c, input logic [12:0] sb,
                                               input logic [2:0] n, input logic [7:0] wi,
                                               input logic [31:0] wd);
    result_t r;
    logic [31:0] m;
    int w;
    int b;
    int top;
    int used;
    bit found;
    r = '0;
    r.status = ST_ILLEGAL;
    case (c)
      CMD_ALLOC: begin
        if (n >= 1 && n <= 4) begin
          m = (32'd1 << n) - 32'd1;
          r.status = ST_NOSPACE;
          found = 1'b0;
          // First fit: lowest word, then lowest bit; a run never spans two words.
          for (w = 0; w < NUM_WORDS && !found; w++) begin
            for (b = 0; b + int'(n) <= 32 && !found; b++) begin
              if (((~usage_words[w] >> b) & m) == m) begin
                usage_words[w] |= m << b;
                map_dirty_q = 1'b1;
                r.block_index = 13'(w * 32 + b);
                r.byte_offset = 32'(MAP_BYTES) + 32'(w * 32 + b) * 32'(block_bytes);
                r.status = ST_OK;
                found = 1'b1;
              end
            end
          end
        end
      end
      CMD_FREE, CMD_VERIFY: begin
        if (n >= 1 && n <= 4) begin
          if (int'(sb[4:0]) + int'(n) > 32) begin
            // A run across a word boundary: free reports it apart, verify does not.
            r.status = (c == CMD_FREE) ? ST_CROSS : ST_ILLEGAL;
          end else begin
            m = ((32'd1 << n) - 32'd1) << sb[4:0];
            if ((usage_words[sb[12:5]] & m) != m) begin
              r.status = ST_NOTALLOC;
            end else begin
              r.status = ST_OK;
              if (c == CMD_FREE) begin
                usage_words[sb[12:5]] ^= m;
                map_dirty_q = 1'b1;
              end
            end
          end
        end
      end
      CMD_SIZE: begin
        used = 0;
        for (w = NUM_WORDS - 1; w >= 0 && used == 0; w--) begin
          if (usage_words[w] != 32'd0) begin
            top = 0;
            for (b = 0; b < 32; b++) begin
              if (usage_words[w][b]) begin
                top = b;
              end
            end
            used = w * 32 + top + 1;
          end
        end
        r.used_blocks = 14'(used);
        r.estimated_size = 32'(MAP_BYTES) + 32'(used) * 32'(block_bytes);
        r.status = ST_OK;
      end
      CMD_LOAD: begin
        // Loading leaves the dirty flag alone.
        usage_words[wi] = wd;
        r.status = ST_OK;
      end
      CMD_READ: begin
        r.word_out = usage_words[wi];
        map_dirty_q = 1'b0;
        r.status = ST_OK;
      end
      default: begin
      end
    endcase
    r.dirty = map_dirty_q;
    return r;
  endfunction

  // Checks each result word against the oldest expectation, then records
  // the expectation of a command word taken at the same edge.
  always @(posedge clk) begin
    result_t exp_r;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result word, status %0d", out_status);
        end
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status || out_block_index !== exp_r.block_index ||
            out_byte_offset !== exp_r.byte_offset ||
            out_used_blocks !== exp_r.used_blocks ||
            out_estimated_size !== exp_r.estimated_size ||
            out_word_out !== exp_r.word_out || out_dirty !== exp_r.dirty) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result differs: status %0d/%0d block %0d/%0d offset %h/%h",
                     exp_r.status, out_status, exp_r.block_index, out_block_index,
                     exp_r.byte_offset, out_byte_offset);
            $display("  used %0d/%0d size %h/%h word %h/%h dirty %0d/%0d",
                     exp_r.used_blocks, out_used_blocks, exp_r.estimated_size,
                     out_estimated_size, exp_r.word_out, out_word_out, exp_r.dirty,
                     out_dirty);
          end
        end
      end
    end
    if (in_valid && in_ready) begin
      pending_results.push_back(allocator_result(in_cmd, in_start_block, in_num_blocks,
                                                 in_word_index, in_word_data));
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request so that
  // the output register fills and the block stops taking words.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_stall_left > 0) begin
      out_ready <= 1'b0;
      out_stall_left--;
    end else if (long_hold_req) begin
      out_ready <= 1'b0;
      out_stall_left = LONG_HOLD;
      long_hold_req = 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      out_stall_left = $urandom_range(1, 18) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a long run of cycles with no word moving on either side is a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("block_bitmap_allocator_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one command word and returns at the edge where it is taken. Valid
  // stays high afterwards so back-to-back words need no second assignment.
  task automatic send_command(input logic [2:0] c, input logic [12:0] sb,
                              input logic [2:0] n, input logic [7:0] wi,
                              input logic [31:0] wd);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= c;
    in_start_block <= sb;
    in_num_blocks  <= n;
    in_word_index  <= wi;
    in_word_data   <= wd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // The block size may only change while the block is idle.
  task automatic set_block_size(input logic [16:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    block_bytes = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed;
    // Every legal run length, plus several rejected ones.
    send_command(CMD_ALLOC, 13'd0, 3'd1, 8'd0, 32'd0);
    send_command(CMD_ALLOC, 13'd0, 3'd4, 8'd0, 32'd0);
    send_command(CMD_ALLOC, 13'd0, 3'd2, 8'd0, 32'd0);
    send_command(CMD_ALLOC, 13'd0, 3'd3, 8'd0, 32'd0);
    send_command(CMD_ALLOC, 13'd0, 3'd0, 8'd0, 32'd0);
    send_command(CMD_ALLOC, 13'd0, 3'd5, 8'd0, 32'd0);
    send_command(CMD_ALLOC, 13'h1FFF, 3'd7, 8'hFF, 32'hFFFFFFFF);
    send_command(CMD_SIZE, 13'd0, 3'd0, 8'd0, 32'd0);
    send_command(CMD_READ, 13'd0, 3'd0, 8'd0, 32'd0);
    send_command(CMD_VERIFY, 13'd1, 3'd4, 8'd0, 32'd0);
    send_command(CMD_VERIFY, 13'd8, 3'd4, 8'd0, 32'd0);
    // Runs crossing a word edge, and a bad length on free and verify.
    send_command(CMD_VERIFY, 13'd30, 3'd4, 8'd0, 32'd0);
    send_command(CMD_FREE, 13'd30, 3'd4, 8'd0, 32'd0);
    send_command(CMD_FREE, 13'd1, 3'd0, 8'd0, 32'd0);
    send_command(CMD_VERIFY, 13'd1, 3'd6, 8'd0, 32'd0);
    send_command(CMD_FREE, 13'd1, 3'd4, 8'd0, 32'd0);
    send_command(CMD_FREE, 13'd1, 3'd4, 8'd0, 32'd0);
    // The top word of the map, loaded full and read back.
    send_command(CMD_LOAD, 13'd0, 3'd0, 8'hFF, 32'hFFFFFFFF);
    send_command(CMD_SIZE, 13'd0, 3'd0, 8'd0, 32'd0);
    send_command(CMD_VERIFY, 13'h1FFF, 3'd1, 8'd0, 32'd0);
    send_command(CMD_READ, 13'd0, 3'd0, 8'hFF, 32'd0);
    send_command(CMD_LOAD, 13'd0, 3'd0, 8'hFF, 32'd0);
    send_command(CMD_UNUSED_A, 13'd0, 3'd1, 8'd0, 32'd0);
    send_command(CMD_UNUSED_B, 13'h1FFF, 3'd7, 8'hFF, 32'hFFFFFFFF);
  endtask

  // Fills the whole map so allocation finds no room, then leaves one gap.
  task automatic test_full_map;
    for (int w = 0; w < NUM_WORDS; w++) begin
      send_command(CMD_LOAD, 13'd0, 3'd0, 8'(w), 32'hFFFFFFFF);
    end
    send_command(CMD_ALLOC, 13'd0, 3'd1, 8'd0, 32'd0);
    send_command(CMD_SIZE, 13'd0, 3'd0, 8'd0, 32'd0);
    send_command(CMD_LOAD, 13'd0, 3'd0, 8'd200, 32'hF0FFFFFF);
    send_command(CMD_ALLOC, 13'd0, 3'd4, 8'd0, 32'd0);
    send_command(CMD_ALLOC, 13'd0, 3'd1, 8'd0, 32'd0);
    for (int w = 0; w < NUM_WORDS; w++) begin
      send_command(CMD_LOAD, 13'd0, 3'd0, 8'(w), 32'd0);
    end
    send_command(CMD_SIZE, 13'd0, 3'd0, 8'd0, 32'd0);
  endtask

  // Random command words, weighted toward the low words where allocations sit
  // so that frees and verifies mostly hit real runs.
  task automatic test_random_mix(input int count);
    logic [2:0]  c;
    logic [12:0] sb;
    logic [2:0]  n;
    logic [7:0]  wi;
    logic [31:0] wd;
    int r;
    for (int k = 0; k < count; k++) begin
      r  = $urandom_range(0, 99);
      sb = 13'($urandom_range(0, HOT_WORDS * 32 - 1));
      n  = 3'($urandom_range(1, 4));
      wi = 8'($urandom_range(0, HOT_WORDS - 1));
      wd = $urandom();
      if ($urandom_range(0, 9) == 0) begin
        sb = 13'($urandom());
        n  = 3'($urandom());
        wi = 8'($urandom());
      end
      if (r < 35) begin
        c = CMD_ALLOC;
      end else if (r < 55) begin
        c = CMD_FREE;
      end else if (r < 65) begin
        c = CMD_VERIFY;
      end else if (r < 72) begin
        c = CMD_SIZE;
      end else if (r < 82) begin
        c = CMD_LOAD;
        if ($urandom_range(0, 2) == 0) begin
          wd = 32'd0;
        end
      end else if (r < 96) begin
        c = CMD_READ;
      end else begin
        c = ($urandom_range(0, 1) == 0) ? CMD_UNUSED_A : CMD_UNUSED_B;
      end
      send_command(c, sb, n, wi, wd);
    end
  endtask

  // The result side stops for a long time while words keep being offered.
  task automatic test_backpressure;
    long_hold_req = 1'b1;
    for (int k = 0; k < 6; k++) begin
      send_command(CMD_VERIFY, 13'(k), 3'd1, 8'd0, 32'd0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_ALLOC;
    in_start_block = '0;
    in_num_blocks = '0;
    in_word_index = '0;
    in_word_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    out_ready = 1'b0;
    out_stall_left = 0;
    long_hold_req = 1'b0;
    no_idle = 1'b0;
    mismatch_count = 0;
    quiet_cycles = 0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      usage_words[w] = 32'd0;
    end
    map_dirty_q = 1'b0;
    block_bytes = 17'd256;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    set_block_size(17'd1);
    test_full_map();
    set_block_size(17'h10000);
    test_random_mix(100);
    set_block_size(17'd0);
    test_random_mix(60);
    set_block_size(17'h1FFFF);
    test_random_mix(80);
    set_block_size(17'($urandom_range(1, 65536)));
    test_random_mix(80);
    set_block_size(17'd512);
    no_idle = 1'b1;
    test_random_mix(80);

    drain();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("block_bitmap_allocator_unit: match");
    end else begin
      $display("block_bitmap_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
